@@ rtl/core/pnfe_pkg.sv @@
// ----------------------------------------------------------------------------
// pnfe_pkg
// Shared types and constants of the Petri net firing engine.
// ----------------------------------------------------------------------------
package pnfe_pkg;

    localparam int MaxPlaces      = 16;
    localparam int MaxTransitions = 16;
    localparam int MaxArcs        = 8;
    localparam int TokenBits      = 16;
    localparam int PlaceW         = $clog2(MaxPlaces);
    localparam int TransW         = $clog2(MaxTransitions);
    localparam int ArcW           = $clog2(MaxArcs);
    localparam int SlotW          = TransW + ArcW;

    typedef enum logic [2:0] {
        ACT_LOAD = 3'd0,
        ACT_PRE  = 3'd1,
        ACT_POST = 3'd2,
        ACT_FIRE = 3'd3,
        ACT_LIST = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_PLACE = 3'd1,
        ST_BAD_TRANS = 3'd2,
        ST_ZERO_WT   = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    localparam logic CFG_PLACE_COUNT = 1'b0;
    localparam logic CFG_TRANS_COUNT = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic             capture;     // latch input item
        logic             do_setup;    // load / arc action, one cycle
        logic             copy_mark;   // copy marking to work copy
        logic             clr_en;      // set enabled flag
        logic             pre_chk;     // check / subtract pre arc
        logic             post_add;
        logic             rd_scan;     // next arc read is for the scan transition
        logic             list_note;   // record scan transition result
        logic [ArcW:0]    k;           // arc slot read for the next cycle
        logic [TransW:0]  rd_t;        // scan transition read for the next cycle
        logic [TransW:0]  scan_t;
        logic             sub_phase;   // pre arcs subtract (fire) vs check
    } pnfe_cmd_t;

    typedef struct packed {
        action_t          action;
        logic             tr_ok;
        logic [ArcW:0]    pre_n;
        logic [ArcW:0]    post_n;
        logic [ArcW:0]    scan_pre_n;
    } pnfe_stat_t;

endpackage

@@ rtl/core/petri_net_firing_engine_core.sv @@
// Sequence: fire checks every pre arc, then subtracts them and adds the post arcs;
// list checks each transition's pre arcs in turn; then one result a cycle unless m_tready stalls.
// Throughput: one item at a time; the arc walk (one arc per cycle) sets the rate.
// Reset (aresetn, synchronous, active low) clears marking, arc totals and
// restores both counts to 16; arc stores are not cleared.
// ----------------------------------------------------------------------------
// petri_net_firing_engine_core
// Weighted Petri net engine: load, add arcs, fire, list enabled transitions.
// ----------------------------------------------------------------------------
module petri_net_firing_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[2:0], place[7:3], transition[12:8], weight[20:13], token_value[36:21]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], item_index[6:3], item_value[22:7], was_enabled[23]
    output logic [23:0] m_tdata,
    output logic        m_tlast
);
    import pnfe_pkg::*;

    pnfe_cmd_t  cmd;
    pnfe_stat_t stat;
    logic       emit_busy, emit_start, emit_list;

    pnfe_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .stat(stat), .emit_busy(emit_busy),
        .emit_start(emit_start), .emit_list(emit_list), .cmd(cmd)
    );

    pnfe_dp u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .in_action(s_tdata[2:0]), .in_place(s_tdata[7:3]),
        .in_transition(s_tdata[12:8]), .in_weight(s_tdata[20:13]),
        .in_token(s_tdata[36:21]),
        .cmd(cmd), .emit_start(emit_start), .emit_list(emit_list),
        .stat(stat), .emit_busy(emit_busy),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_data(m_tdata), .m_last(m_tlast)
    );

endmodule

@@ rtl/core/pnfe_ctrl.sv @@
// ----------------------------------------------------------------------------
// pnfe_ctrl
// Sequencer: walks arcs for fire and list, hands results to the emitter.
// ----------------------------------------------------------------------------
module pnfe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  pnfe_pkg::pnfe_stat_t stat,
    input  logic                emit_busy,
    output logic                emit_start,
    output logic                emit_list,
    output pnfe_pkg::pnfe_cmd_t cmd
);
    import pnfe_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DEC   = 8'b0000_0010,
        S_CHK   = 8'b0000_0100,
        S_SUB   = 8'b0000_1000,
        S_ADD   = 8'b0001_0000,
        S_SCAN  = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_WAIT  = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [ArcW:0]    k_reg, k_next;
    logic [TransW:0]  t_reg, t_next;
    logic             list_reg, list_next;

    assign in_ready = (state_reg == S_IDLE) && !emit_busy;

    // sequencer
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        t_next     = t_reg;
        list_next  = list_reg;
        cmd        = '0;
        cmd.scan_t = t_reg;
        emit_start = 1'b0;
        emit_list  = list_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid && !emit_busy) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC: begin
                k_next = '0;
                t_next = '0;
                case (stat.action)
                    ACT_LOAD, ACT_PRE, ACT_POST: begin
                        cmd.do_setup = 1'b1;
                        list_next    = 1'b0;
                        state_next   = S_EMIT;
                    end
                    ACT_FIRE: begin
                        cmd.copy_mark = 1'b1;
                        cmd.clr_en    = 1'b1;
                        list_next     = 1'b0;
                        state_next    = stat.tr_ok ? S_CHK : S_EMIT;
                    end
                    ACT_LIST: begin
                        cmd.clr_en = 1'b1;
                        list_next  = 1'b1;
                        state_next = S_SCAN;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            // enable check of the fired transition, one pre arc a cycle
            S_CHK: begin
                if (k_reg < stat.pre_n) begin
                    cmd.pre_chk = 1'b1;
                    k_next = k_reg + 1'b1;
                end else begin
                    k_next = '0;
                    state_next = S_SUB;
                end
            end
            S_SUB: begin
                if (k_reg < stat.pre_n) begin
                    cmd.pre_chk   = 1'b1;
                    cmd.sub_phase = 1'b1;
                    k_next = k_reg + 1'b1;
                end else begin
                    k_next = '0;
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                if (k_reg < stat.post_n) begin
                    cmd.post_add = 1'b1;
                    k_next = k_reg + 1'b1;
                end else begin
                    state_next = S_EMIT;
                end
            end
            // list: every transition's pre arcs against stored marking
            S_SCAN: begin
                if (k_reg < stat.scan_pre_n) begin
                    cmd.pre_chk = 1'b1;
                    k_next = k_reg + 1'b1;
                end else begin
                    cmd.list_note = 1'b1;
                    k_next = '0;
                    t_next = t_reg + 1'b1;
                    if (t_reg == TransW'(MaxTransitions - 1)) state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                emit_start = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        // arc store address given the cycle before its use
        cmd.k       = k_next;
        cmd.rd_t    = t_next;
        cmd.rd_scan = (state_next == S_SCAN);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            t_reg     <= '0;
            list_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            t_reg     <= t_next;
            list_reg  <= list_next;
        end
    end

endmodule

@@ rtl/core/pnfe_dp.sv @@
// ----------------------------------------------------------------------------
// pnfe_dp
// Datapath: marking, arc stores, saturating update and result emitter.
// ----------------------------------------------------------------------------
module pnfe_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_idx,
    input  logic [4:0]          cfg_data,
    input  logic [2:0]          in_action,
    input  logic [4:0]          in_place,
    input  logic [4:0]          in_transition,
    input  logic [7:0]          in_weight,
    input  logic [15:0]         in_token,
    input  pnfe_pkg::pnfe_cmd_t cmd,
    input  logic                emit_start,
    input  logic                emit_list,
    output pnfe_pkg::pnfe_stat_t stat,
    output logic                emit_busy,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [23:0]         m_data,
    output logic                m_last
);
    import pnfe_pkg::*;

    localparam int TW = TokenBits;
    localparam logic signed [TW:0] TokMax = (TW+1)'((1 << (TW - 1)) - 1);
    localparam logic signed [TW:0] TokMin = -TokMax - (TW+1)'(1);

    logic [4:0]  np_cfg_reg, nt_cfg_reg;
    logic [4:0]  np, nt;
    logic [2:0]  act_reg;
    logic [4:0]  place_reg, tr_reg;
    logic [7:0]  wt_reg;
    logic [15:0] tok_in_reg;

    logic signed [TW-1:0] tok_reg  [MaxPlaces];
    logic signed [TW-1:0] work_reg [MaxPlaces];
    logic [ArcW:0] pre_tot_reg  [MaxTransitions];
    logic [ArcW:0] post_tot_reg [MaxTransitions];

    // arc stores: small memories, addressed {transition, slot}
    logic [PlaceW+7:0] pre_mem  [MaxTransitions*MaxArcs];
    logic [PlaceW+7:0] post_mem [MaxTransitions*MaxArcs];

    logic                 en_reg;
    logic [2:0]           status_reg;
    logic [3:0]           setup_idx_reg;
    logic signed [15:0]   setup_val_reg;
    logic [TransW:0]      list_cnt_reg;
    logic [TransW-1:0]    list_tr_reg [MaxTransitions];

    // effective counts
    function automatic logic [4:0] eff(input logic [4:0] r, input int lim);
        logic [4:0] n;
        n = r;
        if (n > 5'(lim)) n = 5'(lim);
        if (n > 5'd16) n = 5'd16;
        if (n == 5'd0) n = 5'd1;
        return n;
    endfunction

    assign np = eff(np_cfg_reg, MaxPlaces);
    assign nt = eff(nt_cfg_reg, MaxTransitions);

    logic [TransW-1:0] tr_idx, rd_tr;
    assign tr_idx = tr_reg[TransW-1:0];
    assign rd_tr  = cmd.rd_scan ? cmd.rd_t[TransW-1:0] : tr_idx;

    assign stat.action     = action_t'(act_reg);
    assign stat.tr_ok      = tr_reg < nt;
    assign stat.pre_n      = pre_tot_reg[tr_idx];
    assign stat.post_n     = post_tot_reg[tr_idx];
    assign stat.scan_pre_n = pre_tot_reg[cmd.scan_t[TransW-1:0]];

    // arc read: address given the cycle before, registered data
    logic [SlotW-1:0]  rd_slot;
    logic [PlaceW+7:0] pre_rd_reg, post_rd_reg;
    assign rd_slot = {rd_tr, cmd.k[ArcW-1:0]};
    always_ff @(posedge aclk) begin
        pre_rd_reg  <= pre_mem[rd_slot];
        post_rd_reg <= post_mem[rd_slot];
    end

    logic [PlaceW-1:0]   arc_p;
    logic [7:0]          arc_w;
    logic signed [TW:0]  cur, sum;
    logic signed [TW-1:0] satv;
    assign arc_p = cmd.post_add ? post_rd_reg[PlaceW+7:8] : pre_rd_reg[PlaceW+7:8];
    assign arc_w = cmd.post_add ? post_rd_reg[7:0] : pre_rd_reg[7:0];
    assign cur   = (cmd.sub_phase || cmd.post_add) ?
                   (TW+1)'(work_reg[arc_p]) : (TW+1)'(tok_reg[arc_p]);
    assign sum   = cmd.post_add ? cur + $signed({1'b0, TW'(arc_w)})
                                : cur - $signed({1'b0, TW'(arc_w)});
    assign satv  = (sum > TokMax) ? TokMax[TW-1:0] :
                   (sum < TokMin) ? TokMin[TW-1:0] : sum[TW-1:0];

    // setup checks
    logic [2:0] st_arc;
    logic [ArcW:0] tot_sel;
    always_comb begin
        tot_sel = (act_reg == ACT_PRE) ? pre_tot_reg[tr_idx] : post_tot_reg[tr_idx];
        st_arc  = ST_OK;
        if (act_reg == ACT_PRE) begin
            if (place_reg >= np)   st_arc = ST_BAD_PLACE;
            else if (tr_reg >= nt) st_arc = ST_BAD_TRANS;
        end else begin
            if (tr_reg >= nt)         st_arc = ST_BAD_TRANS;
            else if (place_reg >= np) st_arc = ST_BAD_PLACE;
        end
        if (st_arc == ST_OK && wt_reg == 8'd0) st_arc = ST_ZERO_WT;
        if (st_arc == ST_OK && tot_sel >= (ArcW+1)'(MaxArcs)) st_arc = ST_FULL;
    end

    // control state and marking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            np_cfg_reg <= 5'd16;
            nt_cfg_reg <= 5'd16;
            for (int i = 0; i < MaxPlaces; i++) tok_reg[i] <= '0;
            for (int i = 0; i < MaxTransitions; i++) begin
                pre_tot_reg[i]  <= '0;
                post_tot_reg[i] <= '0;
            end
            en_reg       <= 1'b0;
            list_cnt_reg <= '0;
        end else begin
            if (cfg_we && cfg_idx == CFG_PLACE_COUNT) np_cfg_reg <= cfg_data;
            if (cfg_we && cfg_idx == CFG_TRANS_COUNT) nt_cfg_reg <= cfg_data;
            if (cmd.clr_en) begin
                en_reg       <= 1'b1;
                list_cnt_reg <= '0;
            end
            if (cmd.pre_chk && !cmd.sub_phase && ($signed({1'b0, arc_w}) > cur))
                en_reg <= 1'b0;
            // only transitions in use go on the list
            if (cmd.list_note) begin
                if (en_reg && cmd.scan_t < nt) begin
                    list_tr_reg[list_cnt_reg[TransW-1:0]] <= cmd.scan_t[TransW-1:0];
                    list_cnt_reg <= list_cnt_reg + 1'b1;
                end
                en_reg <= 1'b1;
            end
            if (cmd.do_setup) begin
                if (act_reg == ACT_LOAD && place_reg < np)
                    tok_reg[place_reg[PlaceW-1:0]] <= tok_in_reg;
                if (act_reg == ACT_PRE && st_arc == ST_OK)
                    pre_tot_reg[tr_idx] <= pre_tot_reg[tr_idx] + 1'b1;
                if (act_reg == ACT_POST && st_arc == ST_OK)
                    post_tot_reg[tr_idx] <= post_tot_reg[tr_idx] + 1'b1;
            end
        end
    end

    // input capture, work marking, arc writes, setup result
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg    <= in_action;
            place_reg  <= in_place;
            tr_reg     <= in_transition;
            wt_reg     <= in_weight;
            tok_in_reg <= in_token;
        end
        if (cmd.copy_mark)
            for (int i = 0; i < MaxPlaces; i++) work_reg[i] <= tok_reg[i];
        if ((cmd.pre_chk && cmd.sub_phase && en_reg) || (cmd.post_add && en_reg))
            work_reg[arc_p] <= satv;
        if (cmd.do_setup) begin
            case (act_reg)
                ACT_LOAD: begin
                    status_reg    <= (place_reg < np) ? ST_OK : ST_BAD_PLACE;
                    setup_idx_reg <= place_reg[3:0];
                    setup_val_reg <= (place_reg < np) ? tok_in_reg : 16'd0;
                end
                ACT_PRE, ACT_POST: begin
                    status_reg    <= st_arc;
                    setup_idx_reg <= (st_arc == ST_OK) ? 4'(tot_sel) : 4'd0;
                    setup_val_reg <= 16'd0;
                end
                default: ;
            endcase
            if (act_reg == ACT_PRE && st_arc == ST_OK)
                pre_mem[{tr_idx, tot_sel[ArcW-1:0]}] <= {place_reg[PlaceW-1:0], wt_reg};
            if (act_reg == ACT_POST && st_arc == ST_OK)
                post_mem[{tr_idx, tot_sel[ArcW-1:0]}] <= {place_reg[PlaceW-1:0], wt_reg};
        end
        if (cmd.clr_en) begin
            status_reg <= (act_reg == ACT_FIRE && tr_reg >= nt) ? ST_BAD_TRANS : ST_OK;
        end
    end

    // emitter: output register walks the result run
    logic [1:0]  kind_reg;       // 0 single, 1 marking, 2 list
    logic [4:0]  ecnt_reg, elen_reg;
    logic        fire_en;
    logic [3:0]  eidx;
    logic signed [15:0] evalue;
    assign fire_en = (status_reg == ST_OK) && en_reg;
    assign eidx    = ecnt_reg[3:0];
    always_comb begin
        case (kind_reg)
            2'd1:    evalue = fire_en ? work_reg[eidx] : tok_reg[eidx];
            2'd2:    evalue = (ecnt_reg < 5'(list_cnt_reg)) ?
                              16'(list_tr_reg[eidx]) : -16'sd1;
            default: evalue = setup_val_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid   <= 1'b0;
            emit_busy <= 1'b0;
            ecnt_reg  <= '0;
            elen_reg  <= '0;
            kind_reg  <= '0;
        end else begin
            if (emit_start) begin
                emit_busy <= 1'b1;
                ecnt_reg  <= '0;
                // last result of the previous run may leave this cycle
                if (m_valid && m_ready) m_valid <= 1'b0;
                if (emit_list) begin
                    kind_reg <= 2'd2;
                    elen_reg <= nt;
                end else if (act_reg == ACT_FIRE) begin
                    kind_reg <= 2'd1;
                    elen_reg <= np;
                end else begin
                    kind_reg <= 2'd0;
                    elen_reg <= 5'd1;
                end
            end else if (emit_busy && (!m_valid || m_ready)) begin
                m_valid <= 1'b1;
                m_data  <= {(kind_reg == 2'd1) ? fire_en : 1'b0, evalue,
                            (kind_reg == 2'd0) ? setup_idx_reg : eidx,
                            (kind_reg == 2'd2) ? ST_OK : status_reg};
                m_last  <= (ecnt_reg + 1'b1 == elen_reg);
                ecnt_reg <= ecnt_reg + 1'b1;
                if (ecnt_reg + 1'b1 == elen_reg) emit_busy <= 1'b0;
            end else if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Petri net firing engine: a directed opening and
// random net building, firing and listing under random stalls, with each
// result transfer compared against a marking and arc predictor kept here.
// ----------------------------------------------------------------------------
module tb_top;
    import pnfe_pkg::*;

    // packed with the last field in the lowest bits, as on s_tdata
    typedef struct packed {
        logic [15:0] tokens;
        logic [7:0]  weight;
        logic [4:0]  trans;
        logic [4:0]  place;
        logic [2:0]  action;
    } net_op_t;

    // laid out as {m_tdata, m_tlast}
    typedef struct packed {
        logic        enabled;
        logic [15:0] value;
        logic [3:0]  index;
        logic [2:0]  status;
        logic        last;
    } net_res_t;

    localparam int CycleLimit = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [4:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    net_op_t  op_queue[$];
    net_res_t result_queue[$];
    int       fail_count = 0;
    int       cycle_count = 0;
    bit       calm = 1'b0;      // no idling during this stretch

    // predictor state
    int          place_reg = 16;
    int          trans_reg = 16;
    logic signed [16:0] marking[MaxPlaces];
    logic [3:0]  pre_pl[MaxTransitions][MaxArcs];
    logic [7:0]  pre_wt[MaxTransitions][MaxArcs];
    int          pre_tot[MaxTransitions];
    logic [3:0]  post_pl[MaxTransitions][MaxArcs];
    logic [7:0]  post_wt[MaxTransitions][MaxArcs];
    int          post_tot[MaxTransitions];

    petri_net_firing_engine_core dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    always @(posedge aclk) begin
        if (cycle_count > CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int in_use(int r);
        if (r > 16) return 16;
        if (r == 0) return 1;
        return r;
    endfunction

    function automatic logic signed [16:0] clamp_tokens(int v);
        if (v > 32767) return 17'sd32767;
        if (v < -32768) return -17'sd32768;
        return 17'(v);
    endfunction

    function automatic bit is_enabled(int t);
        for (int k = 0; k < pre_tot[t]; k++)
            if (int'(pre_wt[t][k]) > int'(marking[pre_pl[t][k]])) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void push_result(int st, int idx, int val, bit en, bit lst);
        net_res_t r;
        r.status = 3'(st); r.index = 4'(idx); r.value = 16'(val);
        r.enabled = en; r.last = lst;
        result_queue.push_back(r);
    endfunction

    // expected results of one accepted item; updates the net state
    function automatic void predict_net(net_op_t op);
        int np, nt, st, slot, t;
        int m[MaxPlaces];
        int cnt;
        bit en;
        np = in_use(place_reg);
        nt = in_use(trans_reg);
        t = int'(op.trans);
        case (op.action)
            ACT_LOAD: begin
                if (op.place >= np) push_result(ST_BAD_PLACE, op.place, 0, 0, 1);
                else begin
                    marking[op.place] = 17'($signed(op.tokens));
                    push_result(ST_OK, op.place, int'($signed(op.tokens)), 0, 1);
                end
            end
            ACT_PRE, ACT_POST: begin
                st = ST_OK;
                if (op.action == ACT_PRE) begin
                    if (op.place >= np) st = ST_BAD_PLACE;
                    else if (t >= nt) st = ST_BAD_TRANS;
                end else begin
                    if (t >= nt) st = ST_BAD_TRANS;
                    else if (op.place >= np) st = ST_BAD_PLACE;
                end
                if (st == ST_OK && op.weight == 0) st = ST_ZERO_WT;
                if (st == ST_OK) begin
                    slot = (op.action == ACT_PRE) ? pre_tot[t] : post_tot[t];
                    if (slot >= MaxArcs) st = ST_FULL;
                end
                if (st != ST_OK) push_result(st, 0, 0, 0, 1);
                else begin
                    if (op.action == ACT_PRE) begin
                        pre_pl[t][slot] = op.place[3:0];
                        pre_wt[t][slot] = op.weight;
                        pre_tot[t]++;
                    end else begin
                        post_pl[t][slot] = op.place[3:0];
                        post_wt[t][slot] = op.weight;
                        post_tot[t]++;
                    end
                    push_result(ST_OK, slot, 0, 0, 1);
                end
            end
            ACT_FIRE: begin
                st = ST_OK; en = 0;
                for (int i = 0; i < MaxPlaces; i++) m[i] = int'(marking[i]);
                if (t >= nt) st = ST_BAD_TRANS;
                else if (is_enabled(t)) begin
                    en = 1;
                    for (int k = 0; k < pre_tot[t]; k++)
                        m[pre_pl[t][k]] =
                            int'(clamp_tokens(m[pre_pl[t][k]] - int'(pre_wt[t][k])));
                    for (int k = 0; k < post_tot[t]; k++)
                        m[post_pl[t][k]] =
                            int'(clamp_tokens(m[post_pl[t][k]] + int'(post_wt[t][k])));
                end
                for (int i = 0; i < np; i++) push_result(st, i, m[i], en, i == np - 1);
            end
            ACT_LIST: begin
                cnt = 0;
                for (int i = 0; i < nt; i++)
                    if (is_enabled(i)) begin
                        push_result(ST_OK, cnt, i, 0, cnt == nt - 1);
                        cnt++;
                    end
                for (int i = cnt; i < nt; i++) push_result(ST_OK, i, -1, 0, i == nt - 1);
            end
            default: ;
        endcase
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_net(net_op_t'(s_tdata[36:0]));
            if (!(s_tvalid && !s_tready)) begin
                if (op_queue.size() > 0 && (calm || $urandom_range(99) >= 6)) begin
                    s_tdata <= {3'b000, op_queue.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and back-pressure
    always @(posedge aclk) begin
        net_res_t got, want;
        if (aresetn) begin
            m_tready <= calm || $urandom_range(99) >= 6;
            if (m_tvalid && m_tready) begin
                got = {m_tdata, m_tlast};
                if (result_queue.size() == 0) begin
                    $error("unexpected result transfer %h", got);
                    fail_count++;
                end else begin
                    want = result_queue.pop_front();
                    if (got.status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.index !== want.index) begin
                        $error("item_index exp %0d got %0d", want.index, got.index);
                        fail_count++;
                    end
                    if (got.value !== want.value) begin
                        $error("item_value exp %0d got %0d",
                               $signed(want.value), $signed(got.value));
                        fail_count++;
                    end
                    if (got.enabled !== want.enabled) begin
                        $error("was_enabled exp %0d got %0d", want.enabled, got.enabled);
                        fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last exp %0d got %0d", want.last, got.last);
                        fail_count++;
                    end
                end
            end
        end
    end

    function automatic net_op_t make_op(int a, int p, int t, int w, int v);
        net_op_t op;
        op.action = 3'(a); op.place = 5'(p); op.trans = 5'(t);
        op.weight = 8'(w); op.tokens = 16'(v);
        return op;
    endfunction

    // random item: mostly in range, sometimes anything
    function automatic net_op_t random_op(int np, int nt);
        net_op_t op;
        int r;
        op = make_op(0, 0, 0, 0, 0);
        r = $urandom_range(99);
        op.action = 3'((r < 15) ? int'(ACT_LOAD) : (r < 35) ? int'(ACT_PRE) :
                       (r < 55) ? int'(ACT_POST) : (r < 85) ? int'(ACT_FIRE) :
                       (r < 95) ? int'(ACT_LIST) : int'($urandom_range(7)));
        op.place = 5'(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(np - 1));
        op.trans = 5'(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(nt - 1));
        op.weight = 8'(($urandom_range(19) == 0) ? 0 :
                       ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(1, 6));
        op.tokens = 16'(($urandom_range(4) == 0) ? $urandom_range(65535) : $urandom_range(20));
        return op;
    endfunction

    task automatic wait_idle();
        while (op_queue.size() > 0 || s_tvalid || result_queue.size() > 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, int val);
        @(posedge aclk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= 5'(val);
        if (idx == CFG_PLACE_COUNT) place_reg = val; else trans_reg = val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int np_list[4];
        int nt_list[4];
        np_list = '{16, 1, 0, 31};
        nt_list = '{16, 31, 1, 5};
        for (int i = 0; i < MaxPlaces; i++) marking[i] = '0;
        for (int i = 0; i < MaxTransitions; i++) begin
            pre_tot[i] = 0; post_tot[i] = 0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed opening: extremes, every action, every error code
        op_queue.push_back(make_op(ACT_LOAD, 0, 0, 0, 16'h7fff));
        op_queue.push_back(make_op(ACT_LOAD, 15, 0, 0, 16'h8000));
        op_queue.push_back(make_op(ACT_LOAD, 31, 0, 0, 5));
        op_queue.push_back(make_op(ACT_LOAD, 1, 31, 255, 3));
        op_queue.push_back(make_op(ACT_PRE, 16, 0, 1, 0));
        op_queue.push_back(make_op(ACT_PRE, 0, 16, 1, 0));
        op_queue.push_back(make_op(ACT_POST, 20, 20, 1, 0));
        op_queue.push_back(make_op(ACT_PRE, 0, 0, 0, 0));
        for (int k = 0; k < 9; k++) op_queue.push_back(make_op(ACT_PRE, 1, 2, 1, 0));
        op_queue.push_back(make_op(ACT_POST, 0, 0, 255, 0));
        op_queue.push_back(make_op(ACT_PRE, 15, 1, 255, 0));
        op_queue.push_back(make_op(ACT_FIRE, 0, 0, 0, 0));
        op_queue.push_back(make_op(ACT_FIRE, 0, 1, 0, 0));
        op_queue.push_back(make_op(ACT_FIRE, 0, 2, 0, 0));
        op_queue.push_back(make_op(ACT_FIRE, 0, 31, 0, 0));
        op_queue.push_back(make_op(ACT_LIST, 0, 0, 0, 0));
        op_queue.push_back(make_op(7, 31, 31, 255, 16'hffff));
        wait_idle();

        // random phases across register settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_PLACE_COUNT, np_list[ph]);
            write_reg(CFG_TRANS_COUNT, nt_list[ph]);
            calm = (ph == 2);
            for (int n = 0; n < 50; n++)
                op_queue.push_back(random_op(in_use(place_reg), in_use(trans_reg)));
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

@@ petri_net_firing_engine_core.f @@
rtl/core/pnfe_pkg.sv
rtl/core/pnfe_ctrl.sv
rtl/core/pnfe_dp.sv
rtl/core/petri_net_firing_engine_core.sv
tb/sv/tb_top.sv
